>>> rtl/core/checked_sentence_parser_core_defines.svh
// ----------------------------------------------------------------------------
// Checked sentence parser assertion macros
// Shared concurrent assertion forms for the parser checker.
// ----------------------------------------------------------------------------
`ifndef CHECKED_SENTENCE_PARSER_CORE_DEFINES_SVH
`define CHECKED_SENTENCE_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/csp_pkg.sv
// ----------------------------------------------------------------------------
// Checked sentence parser package
// Transaction types, scan phases and constants of the sentence parser.
// ----------------------------------------------------------------------------
package csp_pkg;

	// Number of colour codes accepted in the best field.
	localparam int COLOR_COUNT = 4;
	localparam logic [7:0] COLOR_LIMIT = 8'(COLOR_COUNT);
	localparam logic [7:0] MASK_BITS = 8'd4;

	localparam logic [7:0] NO_COLOR = 8'hFF;
	localparam logic [16:0] ACC_MAX = 17'h1FFFF;
	localparam logic [16:0] SEQ_MAX = 17'h0FFFF;
	localparam logic [16:0] MASK_MAX = 17'h0000F;
	localparam logic [16:0] BYTE_MAX = 17'd255;
	localparam logic [16:0] COORD_MAX = 17'd2000;

	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_STAR = 8'h2A;
	localparam logic [7:0] CHAR_V = 8'h56;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_PLUS = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_CR = 8'h0D;

	localparam logic [2:0] FIELD_SEQ = 3'd0;
	localparam logic [2:0] FIELD_MASK = 3'd1;
	localparam logic [2:0] FIELD_BEST = 3'd2;
	localparam logic [2:0] FIELD_CONF = 3'd3;
	localparam logic [2:0] FIELD_LAST = 3'd5;

	localparam logic [1:0] HEX_DIGITS = 2'd2;

	typedef enum logic [2:0] {
		PH_V,
		PH_COMMA,
		PH_LEAD,
		PH_SIGNED,
		PH_DIGITS,
		PH_DONE,
		PH_FAIL
	} scan_phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic line_end;
	} char_item_t;

	typedef struct packed {
		logic valid_res;
		logic [15:0] seq_out;
		logic [3:0] mask_out;
		logic [7:0] best_out;
		logic [7:0] conf_out;
	} result_item_t;

endpackage

>>> rtl/core/checked_sentence_parser_core.sv
// ----------------------------------------------------------------------------
// Checked sentence parser core
// Byte-serial parser and XOR checksum check of "V,seq,mask,best,conf,cx,cy*hh".
// ----------------------------------------------------------------------------
// The block takes one character per transaction on the char channel and gives
// one result transaction per line on the result channel, for the byte flagged
// line_end. It sustains one byte per clock: each accepted byte is held in the
// stage-1 register and then folded into the line state by the per-byte update
// logic. The edge that folds a line-end byte also loads its verdict into the
// result register, so a result is offered once its line-end byte has passed
// through the stage-1 register into the result register. Only a line-end byte
// waits in stage 1, and only while the result register still holds a stalled
// result; the byte behind it is stalled at the input meanwhile. Every field of
// a failed line reads as zero. The cx and cy fields are range checked but not
// delivered.
// ----------------------------------------------------------------------------
module checked_sentence_parser_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_stall,
	input  csp_pkg::char_item_t   char_data,
	output logic                  result_valid,
	input  logic                  result_stall,
	output csp_pkg::result_item_t result_data
);
	import csp_pkg::*;

	typedef struct packed {
		logic [7:0] running_xor;
		logic first_byte;
		logic star_seen;
		logic [1:0] hex_count;
		logic [7:0] hex_value;
		logic hex_bad;
		scan_phase_t scan_phase;
		logic [2:0] field_index;
		logic [16:0] number_acc;
		logic number_negative;
		logic range_bad;
		logic [15:0] seq;
		logic [3:0] mask;
		logic [7:0] best;
		logic [7:0] conf;
		logic terminated;
	} line_state_t;

	localparam line_state_t LINE_CLEAR = '{
		running_xor: 8'h00,
		first_byte: 1'b1,
		star_seen: 1'b0,
		hex_count: 2'd0,
		hex_value: 8'h00,
		hex_bad: 1'b0,
		scan_phase: PH_V,
		field_index: 3'd0,
		number_acc: 17'd0,
		number_negative: 1'b0,
		range_bad: 1'b0,
		seq: 16'h0000,
		mask: 4'h0,
		best: 8'h00,
		conf: 8'h00,
		terminated: 1'b0
	};

	// Stage 1: the byte under work.
	logic        valid_s1;
	char_item_t  item_s1;

	// Line state and result register.
	line_state_t  line_q;
	line_state_t  line_next;
	logic         res_valid_q;
	result_item_t res_q;
	result_item_t res_next;

	logic out_free;
	logic advance;
	logic take;
	logic finish_line;

	// Byte classification and number arithmetic.
	logic [7:0]  c;
	logic        is_digit;
	logic        is_blank;
	logic        hex_ok;
	logic [3:0]  hex_nibble;
	logic [20:0] acc_sum;
	logic [16:0] acc_sat;
	logic [16:0] field_limit;
	logic        over_limit;
	logic        number_bad;
	logic        verdict_ok;
	logic        color_ok;

	// ------------------------------------------------------------------
	// Handshake: the result register frees when it is empty or taken this
	// cycle. A line-end byte advances only into a free result register.
	// ------------------------------------------------------------------
	assign out_free    = !res_valid_q || !result_stall;
	assign advance     = valid_s1 && (!item_s1.line_end || out_free);
	assign finish_line = advance && item_s1.line_end;
	assign char_stall  = valid_s1 && !advance;
	assign take        = char_valid && !char_stall;

	assign result_valid = res_valid_q;
	assign result_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the payload while stalled; load only on an accepted transaction.
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= char_data;
		end
	end

	// ------------------------------------------------------------------
	// Byte classification.
	// ------------------------------------------------------------------
	assign c        = item_s1.ch;
	assign is_digit = (c >= 8'h30) && (c <= 8'h39);
	assign is_blank = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));

	always_comb begin
		hex_ok     = 1'b1;
		hex_nibble = 4'h0;
		if (is_digit) begin
			hex_nibble = c[3:0];
		end else if (((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66))) begin
			// Letters a-f and A-F share the low nibble 1..6.
			hex_nibble = 4'(c[3:0] + 4'd9);
		end else begin
			hex_ok = 1'b0;
		end
	end

	// Multiply by ten as two shifts, add the digit, saturate.
	assign acc_sum = 21'({line_q.number_acc, 3'b000}) + 21'({line_q.number_acc, 1'b0})
		+ 21'(c[3:0]);
	assign acc_sat = (acc_sum > 21'(ACC_MAX)) ? ACC_MAX : acc_sum[16:0];

	// Range limit of the number being closed.
	always_comb begin
		unique case (line_q.field_index)
			FIELD_SEQ:  field_limit = SEQ_MAX;
			FIELD_MASK: field_limit = MASK_MAX;
			FIELD_BEST: field_limit = BYTE_MAX;
			FIELD_CONF: field_limit = BYTE_MAX;
			default:    field_limit = COORD_MAX;
		endcase
	end

	assign over_limit = line_q.number_acc > field_limit;
	// Minus zero passes; any other negative value fails.
	assign number_bad = over_limit || (line_q.number_negative && (line_q.number_acc != 17'd0));

	// ------------------------------------------------------------------
	// Next line state for the byte in stage 1.
	// ------------------------------------------------------------------
	always_comb begin
		logic close_number;
		close_number = 1'b0;
		line_next = line_q;
		if (!line_q.terminated) begin
			if (c == CHAR_NUL) begin
				// Drop this and every later byte up to line end.
				line_next.terminated = 1'b1;
			end else if (!line_q.star_seen) begin
				if (c == CHAR_STAR) begin
					if (line_q.first_byte) begin
						line_next.hex_bad = 1'b1;
					end
					line_next.star_seen = 1'b1;
				end else begin
					line_next.running_xor = line_q.running_xor ^ c;
				end

				unique case (line_q.scan_phase)
					PH_V: begin
						line_next.scan_phase = (c == CHAR_V) ? PH_COMMA : PH_FAIL;
					end
					PH_COMMA: begin
						line_next.scan_phase = (c == CHAR_COMMA) ? PH_LEAD : PH_FAIL;
					end
					PH_LEAD, PH_SIGNED, PH_DIGITS: begin
						priority if ((line_q.scan_phase == PH_LEAD) && is_blank) begin
							line_next.scan_phase = PH_LEAD;
						end else if ((line_q.scan_phase == PH_LEAD)
								&& ((c == CHAR_PLUS) || (c == CHAR_MINUS))) begin
							line_next.number_negative = (c == CHAR_MINUS);
							line_next.scan_phase = PH_SIGNED;
						end else if (is_digit) begin
							line_next.number_acc = acc_sat;
							line_next.scan_phase = PH_DIGITS;
						end else if ((line_q.scan_phase == PH_DIGITS)
								&& (line_q.field_index >= FIELD_LAST)) begin
							close_number = 1'b1;
							line_next.scan_phase = PH_DONE;
						end else if ((line_q.scan_phase == PH_DIGITS) && (c == CHAR_COMMA)) begin
							close_number = 1'b1;
							line_next.field_index = 3'(line_q.field_index + 3'd1);
							line_next.scan_phase = PH_LEAD;
						end else begin
							line_next.scan_phase = PH_FAIL;
						end
					end
					default: begin
						line_next.scan_phase = line_q.scan_phase;
					end
				endcase

				if (close_number) begin
					if (number_bad) begin
						line_next.range_bad = 1'b1;
					end
					if (!over_limit) begin
						unique case (line_q.field_index)
							FIELD_SEQ:  line_next.seq = line_q.number_acc[15:0];
							FIELD_MASK: line_next.mask = line_q.number_acc[3:0];
							FIELD_BEST: line_next.best = line_q.number_acc[7:0];
							FIELD_CONF: line_next.conf = line_q.number_acc[7:0];
							default:    line_next.seq = line_q.seq;
						endcase
					end
					line_next.number_acc = 17'd0;
					line_next.number_negative = 1'b0;
				end
			end else if (line_q.hex_count < HEX_DIGITS) begin
				if (!hex_ok) begin
					line_next.hex_bad = 1'b1;
				end
				line_next.hex_value = {line_q.hex_value[3:0], hex_nibble};
				line_next.hex_count = 2'(line_q.hex_count + 2'd1);
			end
			line_next.first_byte = 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Verdict from the state that includes the line-end byte.
	// ------------------------------------------------------------------
	assign color_ok = (line_next.best == NO_COLOR)
		|| ((line_next.best < COLOR_LIMIT) && (line_next.best < MASK_BITS)
			&& line_next.mask[line_next.best[1:0]]);

	assign verdict_ok = line_next.star_seen && (line_next.hex_count == HEX_DIGITS)
		&& !line_next.hex_bad && (line_next.hex_value == line_next.running_xor)
		&& (line_next.scan_phase == PH_DONE) && !line_next.range_bad && color_ok;

	always_comb begin
		res_next.valid_res = verdict_ok;
		res_next.seq_out   = verdict_ok ? line_next.seq : 16'h0000;
		res_next.mask_out  = verdict_ok ? line_next.mask : 4'h0;
		res_next.best_out  = verdict_ok ? line_next.best : 8'h00;
		res_next.conf_out  = verdict_ok ? line_next.conf : 8'h00;
	end

	// Advance the line state; clear it after the line-end byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= LINE_CLEAR;
		end else if (finish_line) begin
			line_q <= LINE_CLEAR;
		end else if (advance) begin
			line_q <= line_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (finish_line) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_line) begin
			res_q <= res_next;
		end
	end

endmodule

>>> rtl/core/csp_checker.sv
// ----------------------------------------------------------------------------
// Checked sentence parser checker
// Port-level assertions on the parser core, bound into every instance of it.
// ----------------------------------------------------------------------------
`include "checked_sentence_parser_core_defines.svh"

module csp_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  char_valid,
	input logic                  char_stall,
	input csp_pkg::char_item_t   char_data,
	input logic                  result_valid,
	input logic                  result_stall,
	input csp_pkg::result_item_t result_data
);
	import csp_pkg::*;

	logic line_end_taken;

	assign line_end_taken = char_valid && !char_stall && char_data.line_end;

	// A failed line delivers all-zero fields.
	`CSP_ASSERT_SAME(a_fail_zero, clk, arst_n, result_valid && !result_data.valid_res, (result_data.seq_out == 16'h0000) && (result_data.mask_out == 4'h0) && (result_data.best_out == 8'h00) && (result_data.conf_out == 8'h00), "failed line with nonzero fields")

	// A passing line names no colour or one that is present in the mask.
	`CSP_ASSERT_SAME(a_best_in_mask, clk, arst_n, result_valid && result_data.valid_res, (result_data.best_out == NO_COLOR) || ((result_data.best_out < COLOR_LIMIT) && (result_data.best_out < MASK_BITS) && result_data.mask_out[result_data.best_out[1:0]]), "passing line with bad best colour")

	// A stalled result holds.
	`CSP_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result_data), "stalled result changed")

	// A result that rises from idle follows an accepted line-end byte.
	`CSP_ASSERT_SAME(a_result_cause, clk, arst_n, $rose(result_valid), $past(line_end_taken, 2), "result without a line-end byte")

endmodule

bind checked_sentence_parser_core csp_checker u_csp_checker (.*);
